// File: sv/fpll_pkg.sv
// Package with shared types and constants of the fractional-N PLL programmer.
`timescale 1ns / 1ps

package fpll_pkg;

    // Field widths of the request and result beats.
    localparam int FREQ_W   = 11;
    localparam int WORD_W   = 32;
    localparam int REGNUM_W = 3;
    localparam int CFG_IDX_W = 3;

    // Product freq * 32 and the divide by 250 done as a reciprocal multiply.
    localparam int PROD_W      = FREQ_W + 5;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_MULT = 17'd67109;
    localparam int QUO_W       = 9;
    localparam logic [7:0] DIV_CONST = 8'd250;
    localparam int FRAC_W      = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] IDX_R5 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_R4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_R3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_R2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_R1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] IDX_R0 = 3'd5;
    localparam int NUM_CFG = 5;

    // Reset values of the fixed register words.
    localparam logic [WORD_W-1:0] RST_R5 = 32'h0058_0005;
    localparam logic [WORD_W-1:0] RST_R4 = 32'h00DC_803C;
    localparam logic [WORD_W-1:0] RST_R3 = 32'h0000_04B3;
    localparam logic [WORD_W-1:0] RST_R2 = 32'h0001_0E42;
    localparam logic [WORD_W-1:0] RST_R1 = 32'h0000_83E9;

    // One configuration write beat.
    typedef struct packed {
        logic                 vld;
        logic [CFG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]    data;
    } cfg_wr_t;

endpackage

// File: sv/fpll_front.sv
// Front end: accepts frequency requests and computes the R0 divider word.
`timescale 1ns / 1ps

module fpll_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [fpll_pkg::FREQ_W-1:0] freq_tenths_mhz,
    input  logic                       q_full,
    output logic                       q_wr,
    output logic [fpll_pkg::WORD_W-1:0] q_wr_data
);
    import fpll_pkg::*;

    localparam int MUL_W = PROD_W + RECIP_W;

    logic                s1_vld_reg;
    logic                s1_vld_next;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic [QUO_W-1:0]    s1_quo_reg;
    logic                accept;
    logic [PROD_W-1:0]   prod;
    logic [MUL_W-1:0]    recip_prod;
    logic [PROD_W:0]     rem_raw;
    logic [PROD_W:0]     rem_fix;
    logic [QUO_W-1:0]    quo_fix;
    logic [FRAC_W-1:0]   frac;

    // Input handshake: the stage register frees up whenever its beat moves on.
    assign full   = s1_vld_reg & q_full;
    assign accept = push & ~full;
    assign q_wr   = s1_vld_reg & ~q_full;

    // Stage 1: product and quotient estimate by reciprocal multiply.
    assign prod       = {freq_tenths_mhz, 5'b0};
    assign recip_prod = MUL_W'(prod) * MUL_W'(RECIP_MULT);

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (accept)
        begin
            s1_vld_next = 1'b1;
        end
        else if (q_wr)
        begin
            s1_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_prod_reg <= prod;
            s1_quo_reg  <= recip_prod[RECIP_SHIFT +: QUO_W];
        end
    end

    // Stage 2: remainder with a one-step correction, then pack the R0 word.
    // FRAC is remainder * 125 / 250, which is the remainder halved.
    always_comb
    begin
        rem_raw = {1'b0, s1_prod_reg}
                  - ((PROD_W+1)'(s1_quo_reg) * (PROD_W+1)'(DIV_CONST));
        rem_fix = rem_raw;
        quo_fix = s1_quo_reg;
        if (rem_raw >= (PROD_W+1)'(DIV_CONST))
        begin
            rem_fix = rem_raw - (PROD_W+1)'(DIV_CONST);
            quo_fix = s1_quo_reg + QUO_W'(1);
        end
        frac = rem_fix[FRAC_W:1];
    end

    assign q_wr_data = {8'b0, quo_fix, 5'b0, frac, 3'b0};

endmodule

// File: sv/fpll_fifo.sv
// Small register queue that decouples the front end from the word sequencer.
`timescale 1ns / 1ps

module fpll_fifo
#(
    parameter int DEPTH = 4,
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             q_full,
    input  logic             rd,
    output logic             q_not_empty,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_full      = (count_reg == CNT_W'(DEPTH));
    assign q_not_empty = (count_reg != '0);
    assign rd_data     = mem_reg[rd_ptr_reg];

    // Pointer wrap and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr && !rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/fpll_back.sv
// Back end: holds the fixed words and sequences R5 down to R0 into the result register.
`timescale 1ns / 1ps

module fpll_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fpll_pkg::cfg_wr_t             cfg_wr,
    input  logic                          q_not_empty,
    input  logic [fpll_pkg::WORD_W-1:0]   q_rd_data,
    output logic                          q_rd,
    output logic                          empty,
    input  logic                          pop,
    output logic [fpll_pkg::WORD_W-1:0]   reg_word,
    output logic [fpll_pkg::REGNUM_W-1:0] reg_number,
    output logic                          last_word
);
    import fpll_pkg::*;

    logic [WORD_W-1:0]    cfg_word_reg [NUM_CFG];
    logic [CFG_IDX_W-1:0] seq_reg;
    logic [CFG_IDX_W-1:0] seq_next;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic [WORD_W-1:0]    out_word_reg;
    logic [REGNUM_W-1:0]  out_num_reg;
    logic                 out_last_reg;
    logic                 load;
    logic                 seq_last;
    logic [WORD_W-1:0]    sel_word;

    // Configuration writes; indexes past R1 are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_word_reg[IDX_R5] <= RST_R5;
            cfg_word_reg[IDX_R4] <= RST_R4;
            cfg_word_reg[IDX_R3] <= RST_R3;
            cfg_word_reg[IDX_R2] <= RST_R2;
            cfg_word_reg[IDX_R1] <= RST_R1;
        end
        else if (cfg_wr.vld && (cfg_wr.idx <= IDX_R1))
        begin
            cfg_word_reg[cfg_wr.idx] <= cfg_wr.data;
        end
    end

    // Word selection for the current step of the sequence.
    assign seq_last = (seq_reg == IDX_R0);

    always_comb
    begin
        case (seq_reg)
            IDX_R5:  sel_word = cfg_word_reg[IDX_R5];
            IDX_R4:  sel_word = cfg_word_reg[IDX_R4];
            IDX_R3:  sel_word = cfg_word_reg[IDX_R3];
            IDX_R2:  sel_word = cfg_word_reg[IDX_R2];
            IDX_R1:  sel_word = cfg_word_reg[IDX_R1];
            default: sel_word = q_rd_data;
        endcase
    end

    // The result register refills when the queue is not empty and it is free or taken.
    assign load = q_not_empty & (~out_vld_reg | pop);
    assign q_rd = load & seq_last;

    always_comb
    begin
        seq_next     = seq_reg;
        out_vld_next = out_vld_reg;
        if (load)
        begin
            seq_next     = seq_last ? IDX_R5 : seq_reg + CFG_IDX_W'(1);
            out_vld_next = 1'b1;
        end
        else if (pop)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= IDX_R5;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            seq_reg     <= seq_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_word_reg <= sel_word;
            out_num_reg  <= REGNUM_W'(IDX_R0 - seq_reg);
            out_last_reg <= seq_last;
        end
    end

    assign empty      = ~out_vld_reg;
    assign reg_word   = out_word_reg;
    assign reg_number = out_num_reg;
    assign last_word  = out_last_reg;

endmodule

// File: sv/fracn_pll_freq_programmer.sv
// Top level of the fractional-N PLL frequency programmer.
`timescale 1ns / 1ps
// Usage:
// The request side is a queue input: drive freq_tenths_mhz with push; a beat is
// taken at a clock edge with push high and full low. Each beat yields six result
// beats, register words R5, R4, R3, R2, R1 and then R0, with reg_number counting
// 5 down to 0 and last_word set on R0. The result side is a queue output: the
// oldest word is on the ports while empty is low and is taken when pop is high.
// R0 is computed in two pipeline stages (reciprocal multiply, then remainder and
// packing) and lands in a small queue ahead of the result register. The sequencer
// emits one word per cycle while a request is queued and the result register is
// free or popped; requests are taken back to back until the queue fills.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// the fixed words R5..R1 at indexes 0..4; cfg_ready is always high and writes to
// other indexes are dropped. Write only while no request is in flight.
// Reset restores the default fixed words and empties every stage. When the
// receiver holds pop low, the result register keeps its word, the queue fills,
// and full rises once both the queue and the front stage are occupied.
module fracn_pll_freq_programmer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [fpll_pkg::FREQ_W-1:0]   freq_tenths_mhz,
    output logic                          empty,
    input  logic                          pop,
    output logic [fpll_pkg::WORD_W-1:0]   reg_word,
    output logic [fpll_pkg::REGNUM_W-1:0] reg_number,
    output logic                          last_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fpll_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fpll_pkg::WORD_W-1:0]   cfg_data
);
    import fpll_pkg::*;

    logic              q_full;
    logic              q_wr;
    logic [WORD_W-1:0] q_wr_data;
    logic              q_rd;
    logic              q_not_empty;
    logic [WORD_W-1:0] q_rd_data;
    cfg_wr_t           cfg_wr;

    // Configuration beat.
    assign cfg_ready   = 1'b1;
    assign cfg_wr.vld  = cfg_valid;
    assign cfg_wr.idx  = cfg_index;
    assign cfg_wr.data = cfg_data;

    fpll_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .freq_tenths_mhz (freq_tenths_mhz),
        .q_full          (q_full),
        .q_wr            (q_wr),
        .q_wr_data       (q_wr_data)
    );

    fpll_fifo
    #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WORD_W)
    )
    u_fifo
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (q_wr),
        .wr_data     (q_wr_data),
        .q_full      (q_full),
        .rd          (q_rd),
        .q_not_empty (q_not_empty),
        .rd_data     (q_rd_data)
    );

    fpll_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr      (cfg_wr),
        .q_not_empty (q_not_empty),
        .q_rd_data   (q_rd_data),
        .q_rd        (q_rd),
        .empty       (empty),
        .pop         (pop),
        .reg_word    (reg_word),
        .reg_number  (reg_number),
        .last_word   (last_word)
    );

`ifndef SYNTHESIS
    // The flag on the final word agrees with its register number.
    a_last_matches_num: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_word == (reg_number == 3'd0)))
        else $error("last_word disagrees with reg_number");

    // Within a sequence the next word follows right after a pop.
    a_seq_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_word) |=> !empty)
        else $error("gap inside a register word sequence");

    // Register numbers count down by one inside a sequence.
    a_seq_countdown: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_word) |=> (reg_number == $past(reg_number) - 3'd1))
        else $error("register number did not count down");

    // The queue is never read while it holds nothing.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> q_not_empty)
        else $error("read of an empty queue");
`endif

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the fractional-N PLL frequency programmer.
`timescale 1ns / 1ps

module tb;

    import fpll_pkg::*;

    // Run limits and pacing.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_BEAT_A  = 300;
    localparam int HOLD_BEAT_B  = 1800;
    localparam int DIRECTED_N   = 18;

    // Indexes past the last fixed word; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_SPARE7 = 3'd7;

    typedef enum int {FILL_DEFAULTS, FILL_ONES, FILL_ZEROS, FILL_RANDOM} word_fill_t;

    // One result beat as the sequencer should emit it.
    typedef struct {
        logic [WORD_W-1:0]   word;
        logic [REGNUM_W-1:0] num;
        logic                last;
    } pll_beat_t;

    // One directed request; r0 is only used when has_r0 is set.
    typedef struct {
        logic [FREQ_W-1:0] freq;
        bit                has_r0;
        logic [WORD_W-1:0] r0;
    } freq_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [FREQ_W-1:0]    freq_tenths_mhz = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [WORD_W-1:0]    reg_word;
    logic [REGNUM_W-1:0]  reg_number;
    logic                 last_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data = '0;

    // Local copy of the fixed words R5..R1, indexed like the write channel.
    logic [WORD_W-1:0] fixed_word [0:NUM_CFG-1];
    pll_beat_t         pending_words [$];
    int                err_count = 0;
    int                cycle_count = 0;
    int                beats_seen = 0;

    // Directed requests: extremes, exact divisions, largest fraction, bit patterns.
    freq_row_t directed_rows [0:DIRECTED_N-1] = '{
        '{11'd0,    1'b1, 32'h0000_0000},
        '{11'd2047, 1'b1, 32'h0083_0010},
        '{11'd1,    1'b1, 32'h0000_0080},
        '{11'd125,  1'b1, 32'h0008_0000},
        '{11'd1000, 1'b1, 32'h0040_0000},
        '{11'd39,   1'b0, 32'h0},
        '{11'h555,  1'b0, 32'h0},
        '{11'h2AA,  1'b0, 32'h0},
        '{11'h400,  1'b0, 32'h0},
        '{11'h3FF,  1'b0, 32'h0},
        '{11'h7FE,  1'b0, 32'h0},
        '{11'd250,  1'b0, 32'h0},
        '{11'd8,    1'b0, 32'h0},
        '{11'd124,  1'b0, 32'h0},
        '{11'd126,  1'b0, 32'h0},
        '{11'd1024, 1'b0, 32'h0},
        '{11'd2000, 1'b0, 32'h0},
        '{11'd2046, 1'b0, 32'h0}
    };

    fracn_pll_freq_programmer dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .freq_tenths_mhz (freq_tenths_mhz),
        .empty           (empty),
        .pop             (pop),
        .reg_word        (reg_word),
        .reg_number      (reg_number),
        .last_word       (last_word),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #4 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[fracn_pll_freq_programmer] ERROR");
            $finish;
        end
    end

    // R0 word: INT and FRAC of freq * 32 over a step of 250 with modulus 125.
    function automatic logic [WORD_W-1:0] pll_r0_word(logic [FREQ_W-1:0] f);
        int unsigned prod;
        int unsigned int_part;
        int unsigned frac_part;
        prod      = 32'(f) * 32;
        int_part  = prod / 250;
        frac_part = ((prod % 250) * 125) / 250;
        return WORD_W'((int_part << 15) + (frac_part << 3));
    endfunction

    // Queue the six words one request should produce.
    task automatic expect_sequence(logic [FREQ_W-1:0] f, bit has_r0, logic [WORD_W-1:0] r0);
        pll_beat_t b;
        for (int k = 0; k < NUM_CFG; k++)
        begin
            b.word = fixed_word[k];
            b.num  = REGNUM_W'(5 - k);
            b.last = 1'b0;
            pending_words.push_back(b);
        end
        b.word = has_r0 ? r0 : pll_r0_word(f);
        b.num  = '0;
        b.last = 1'b1;
        pending_words.push_back(b);
    endtask

    // Wait until every expected word has come, then let the pipeline settle.
    task automatic wait_drained();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Offer one request beat; afterwards idle for the given gap and, if asked, until drained.
    task automatic send_freq(logic [FREQ_W-1:0] f, bit has_r0, logic [WORD_W-1:0] r0,
                             int gap, bit drain_after);
        push            <= 1'b1;
        freq_tenths_mhz <= f;
        do @(posedge clk); while (full);
        expect_sequence(f, has_r0, r0);
        if (gap > 0 || drain_after)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
            if (drain_after)
                wait_drained();
        end
    endtask

    // One configuration write beat.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx < NUM_CFG)
            fixed_word[idx] = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Rewrite all fixed words, plus writes to unused indexes that must be dropped.
    task automatic load_fixed_words(word_fill_t fill);
        logic [CFG_IDX_W-1:0] idx_list [0:NUM_CFG-1];
        logic [WORD_W-1:0]    value;
        idx_list = '{IDX_R5, IDX_R4, IDX_R3, IDX_R2, IDX_R1};
        for (int k = 0; k < NUM_CFG; k++)
        begin
            case (fill)
                FILL_ONES:   value = '1;
                FILL_ZEROS:  value = '0;
                FILL_RANDOM: value = $urandom;
                default:     value = fixed_word[k];
            endcase
            write_cfg(idx_list[k], value);
        end
        write_cfg(IDX_R0, $urandom);
        write_cfg(IDX_SPARE6, $urandom);
        write_cfg(IDX_SPARE7, '1);
    endtask

    // Random requests with bursts of back-to-back beats and an optional mid pause.
    task automatic run_random(int count, bit mid_pause);
        logic [FREQ_W-1:0] f;
        int                gap;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 11))
                0:       f = '0;
                1:       f = '1;
                2:       f = 11'd39;
                default: f = FREQ_W'($urandom_range(0, 2047));
            endcase
            gap = ((i % 40) < 10) ? 0 : $urandom_range(0, 19);
            send_freq(f, 1'b0, '0, gap, (i == count - 1) || (mid_pause && i == count / 2));
        end
    endtask

    // Result side: random stalls, long hold-offs, and a field-by-field check.
    initial
    begin
        int        stall;
        pll_beat_t exp_beat;
        wait (rst_n);
        forever
        begin
            if (beats_seen == HOLD_BEAT_A || beats_seen == HOLD_BEAT_B)
                stall = HOLD_CYCLES;
            else if ((beats_seen / 64) % 4 == 0)
                stall = 0;
            else
                stall = $urandom_range(0, 19);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            beats_seen++;
            if (pending_words.size() == 0)
            begin
                $error("unexpected result beat: reg_word %h reg_number %0d", reg_word,
                       reg_number);
                err_count++;
            end
            else
            begin
                exp_beat = pending_words.pop_front();
                if (reg_word !== exp_beat.word)
                begin
                    $error("reg_word: expected %h, actual %h", exp_beat.word, reg_word);
                    err_count++;
                end
                if (reg_number !== exp_beat.num)
                begin
                    $error("reg_number: expected %0d, actual %0d", exp_beat.num, reg_number);
                    err_count++;
                end
                if (last_word !== exp_beat.last)
                begin
                    $error("last_word: expected %b, actual %b", exp_beat.last, last_word);
                    err_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed rows, then random phases under several settings.
    initial
    begin
        fixed_word = '{32'h0058_0005, 32'h00DC_803C, 32'h0000_04B3,
                       32'h0001_0E42, 32'h0000_83E9};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
            send_freq(directed_rows[i].freq, directed_rows[i].has_r0, directed_rows[i].r0,
                      $urandom_range(0, 19), i == DIRECTED_N - 1);
        run_random(100, 1'b0);

        load_fixed_words(FILL_ONES);
        run_random(100, 1'b1);

        load_fixed_words(FILL_ZEROS);
        run_random(100, 1'b0);

        load_fixed_words(FILL_RANDOM);
        run_random(112, 1'b0);

        wait_drained();
        if (err_count == 0)
            $display("[fracn_pll_freq_programmer] OK");
        else
            $display("[fracn_pll_freq_programmer] ERROR");
        $finish;
    end

endmodule
